// ===== rtl/sms_pkg.sv =====
package sms_pkg;

  localparam int MAX_ELEMENTS_DEF = 64;
  localparam int LOGIT_W = 16;
  localparam int TERM_W = 17;
  localparam int VALUE_W = 18;
  localparam int TDATA_IN_W = 16;
  localparam int TDATA_OUT_W = 24;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam int DIV_STEPS = 17;
  localparam logic [16:0] LOG2E_Q16 = 17'd94548;
  localparam logic [TERM_W-1:0] ONE_Q16 = 17'd65536;
  localparam logic [0:0] REG_GRADIENT_MODE = 1'b0;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_EXP_RD,
    ST_EXP_MUL,
    ST_EXP_ACC,
    ST_DIV_RD,
    ST_DIV_INIT,
    ST_DIV_STEP,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load_en;
    logic exp_rd;
    logic exp_mul;
    logic exp_acc;
    logic div_rd;
    logic div_init;
    logic div_step;
    logic out_load;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic last_in;
    logic idx_last;
    logic div_last;
    logic out_free;
  } status_t;

  function automatic logic [TERM_W-1:0] exp2_frac(input logic [3:0] k);
    logic [TERM_W-1:0] r;
    case (k)
      4'd0: r = 17'd65536;
      4'd1: r = 17'd62757;
      4'd2: r = 17'd60097;
      4'd3: r = 17'd57549;
      4'd4: r = 17'd55109;
      4'd5: r = 17'd52773;
      4'd6: r = 17'd50535;
      4'd7: r = 17'd48393;
      4'd8: r = 17'd46341;
      4'd9: r = 17'd44376;
      4'd10: r = 17'd42495;
      4'd11: r = 17'd40693;
      4'd12: r = 17'd38968;
      4'd13: r = 17'd37316;
      4'd14: r = 17'd35734;
      default: r = 17'd34219;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/sms_ctrl.sv =====
module sms_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_accept,
  input  sms_pkg::status_t  status,
  output sms_pkg::cmd_t     cmd,
  output logic              in_ready
);
  import sms_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD: begin
        if (s_accept && status.last_in) begin
          state_next = ST_EXP_RD;
        end
      end
      ST_EXP_RD: state_next = ST_EXP_MUL;
      ST_EXP_MUL: state_next = ST_EXP_ACC;
      ST_EXP_ACC: state_next = status.idx_last ? ST_DIV_RD : ST_EXP_RD;
      ST_DIV_RD: state_next = ST_DIV_INIT;
      ST_DIV_INIT: state_next = ST_DIV_STEP;
      ST_DIV_STEP: begin
        if (status.div_last) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (status.out_free) begin
          state_next = status.idx_last ? ST_LOAD : ST_DIV_RD;
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      ST_LOAD: begin
        in_ready = 1'b1;
        cmd.load_en = s_accept;
      end
      ST_EXP_RD: cmd.exp_rd = 1'b1;
      ST_EXP_MUL: cmd.exp_mul = 1'b1;
      ST_EXP_ACC: cmd.exp_acc = 1'b1;
      ST_DIV_RD: cmd.div_rd = 1'b1;
      ST_DIV_INIT: cmd.div_init = 1'b1;
      ST_DIV_STEP: cmd.div_step = 1'b1;
      ST_OUT: begin
        cmd.out_load = status.out_free;
        cmd.clear = status.out_free && status.idx_last;
      end
      default: cmd = '0;
    endcase
  end

endmodule

// ===== rtl/sms_dp.sv =====
module sms_dp #(
  parameter int MAX_ELEMENTS = sms_pkg::MAX_ELEMENTS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  sms_pkg::cmd_t                        cmd,
  output sms_pkg::status_t                     status,
  input  logic                                 gradient_mode,
  input  logic signed [sms_pkg::LOGIT_W-1:0]   logit,
  input  logic                                 target_hot,
  input  logic                                 last_element,
  output logic signed [sms_pkg::VALUE_W-1:0]   value,
  output logic                                 last_result,
  output logic                                 out_valid,
  input  logic                                 out_ready
);
  import sms_pkg::*;

  localparam int IDX_W = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
  localparam int TOT_W = TERM_W + ((MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 0);
  localparam int REM_W = TOT_W + 1;
  localparam int NUM_W = TERM_W + 16 + 1;
  localparam int Y_W = LOGIT_W + 17;

  logic signed [LOGIT_W-1:0] logit_mem [MAX_ELEMENTS];
  logic [TERM_W-1:0]         exp_mem [MAX_ELEMENTS];
  logic                      target_mem [MAX_ELEMENTS];

  logic [CNT_W-1:0]          count;
  logic signed [LOGIT_W-1:0] running_max;
  logic [TOT_W-1:0]          exp_total;
  logic [IDX_W-1:0]          idx;
  logic signed [LOGIT_W-1:0] rd_logit;
  logic [TERM_W-1:0]         rd_exp;
  logic                      rd_tgt;
  logic [Y_W-1:0]            y;
  logic [REM_W-1:0]          rem;
  logic [DIV_STEPS-1:0]      quot;
  logic [4:0]                step;

  logic [LOGIT_W-1:0]        diff;
  logic [8:0]                shift_n;
  logic [TERM_W-1:0]         term;
  logic [NUM_W-1:0]          num;
  logic [REM_W-1:0]          rem_shift;
  logic                      rem_ge;
  logic                      out_taken;

  assign out_taken = out_valid && out_ready;
  assign status.last_in = last_element;
  assign status.idx_last = (CNT_W'(idx) == count - CNT_W'(1));
  assign status.div_last = (step == 5'(DIV_STEPS - 1));
  assign status.out_free = !out_valid || out_ready;

  // d = max - x is always non-negative and fits 16 bits unsigned.
  assign diff = LOGIT_W'(running_max - rd_logit);
  assign shift_n = y[Y_W-1:24];
  assign term = (shift_n >= 9'd17) ? '0 : (exp2_frac(y[23:20]) >> shift_n[4:0]);
  assign num = (NUM_W'(rd_exp) << 16) + NUM_W'(exp_total >> 1);
  assign rem_shift = {rem[REM_W-2:0], quot[DIV_STEPS-1]};
  assign rem_ge = (rem_shift >= REM_W'(exp_total));

  always_ff @(posedge clk) begin
    if (cmd.load_en && (count < CNT_W'(MAX_ELEMENTS))) begin
      logit_mem[idx] <= logit;
      target_mem[idx] <= target_hot;
    end
    if (cmd.exp_acc) begin
      exp_mem[idx] <= term;
    end
    if (cmd.exp_rd) begin
      rd_logit <= logit_mem[idx];
    end
    if (cmd.div_rd) begin
      rd_exp <= exp_mem[idx];
      rd_tgt <= target_mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exp_mul) begin
      y <= Y_W'(diff) * Y_W'(LOG2E_Q16);
    end
    if (cmd.div_init) begin
      // The top part of the numerator is already below the divisor.
      rem <= REM_W'(num[NUM_W-1:DIV_STEPS]);
      quot <= num[DIV_STEPS-1:0];
    end else if (cmd.div_step) begin
      rem <= rem_ge ? (rem_shift - REM_W'(exp_total)) : rem_shift;
      quot <= {quot[DIV_STEPS-2:0], rem_ge};
    end
    if (cmd.out_load) begin
      value <= $signed({1'b0, quot}) -
               ((gradient_mode && rd_tgt) ? $signed({1'b0, ONE_Q16}) : 18'sd0);
      last_result <= status.idx_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      running_max <= '0;
      exp_total <= '0;
      idx <= '0;
      step <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load_en) begin
        if (count < CNT_W'(MAX_ELEMENTS)) begin
          if ((count == '0) || (logit > running_max)) begin
            running_max <= logit;
          end
          count <= count + CNT_W'(1);
          idx <= idx + IDX_W'(1);
        end
        if (last_element) begin
          idx <= '0;
          exp_total <= '0;
        end
      end
      if (cmd.exp_acc) begin
        exp_total <= exp_total + TOT_W'(term);
        idx <= status.idx_last ? '0 : idx + IDX_W'(1);
      end
      if (cmd.div_init) begin
        step <= '0;
      end else if (cmd.div_step) begin
        step <= step + 5'd1;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
        idx <= status.idx_last ? '0 : idx + IDX_W'(1);
      end else if (out_taken) begin
        out_valid <= 1'b0;
      end
      if (cmd.clear) begin
        count <= '0;
        running_max <= '0;
        exp_total <= '0;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_ELEMENTS))
    else $error("element count beyond capacity");

  a_total_floor: assert property (@(posedge clk) disable iff (rst)
    cmd.div_init |-> (exp_total >= TOT_W'(ONE_Q16)))
    else $error("exponent sum below one at division");

  a_value_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((value >= -18'sd65536) && (value <= 18'sd65536)))
    else $error("result out of Q1.16 range");

  a_out_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !cmd.out_load)
    else $error("pending result overwritten");

endmodule

// ===== rtl/softmax_with_gradient.sv =====
// Loading accepts words only in the load state; the word flagged tlast starts the computation.
// Exponent pass, per stored element: memory read, log2e multiply, then shift and sum.
// Division pass: per element a read, setup, 17 restoring steps and an output load that waits
// while the previous result is still held; the divider yields one quotient bit per cycle.
// Reset (synchronous, active high) clears the count, maximum, sum, divider step counter and
// output valid and sets gradient_mode to 0; the element stores are written before they are read.
module softmax_with_gradient #(
  parameter int MAX_ELEMENTS = sms_pkg::MAX_ELEMENTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [sms_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [sms_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [sms_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                pready,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [sms_pkg::TDATA_IN_W-1:0]      s_axis_tdata,  // [15:0] logit
  input  logic                                s_axis_tuser,  // [0] target_hot
  input  logic                                s_axis_tlast,  // last_element
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [sms_pkg::TDATA_OUT_W-1:0]     m_axis_tdata,  // [17:0] value, rest zero
  output logic                                m_axis_tlast   // last_result
);
  import sms_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic    gradient_mode;
  logic    s_accept;
  logic    cfg_write;
  logic signed [VALUE_W-1:0] value;

  // Registers sit at byte address 4*i, so the word index is paddr above bit 1.
  assign pready = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign prdata = (paddr[APB_ADDR_W-1:2] == REG_GRADIENT_MODE) ?
                  APB_DATA_W'(gradient_mode) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      gradient_mode <= 1'b0;
    end else if (cfg_write && (paddr[APB_ADDR_W-1:2] == REG_GRADIENT_MODE)) begin
      gradient_mode <= pwdata[0];
    end
  end

  assign s_accept = s_axis_tvalid && s_axis_tready;

  // The controller only sequences; the element storage and all arithmetic live in the datapath.
  sms_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_accept (s_accept),
    .status   (status),
    .cmd      (cmd),
    .in_ready (s_axis_tready)
  );

  sms_dp #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .gradient_mode (gradient_mode),
    .logit         ($signed(s_axis_tdata)),
    .target_hot    (s_axis_tuser),
    .last_element  (s_axis_tlast),
    .value         (value),
    .last_result   (m_axis_tlast),
    .out_valid     (m_axis_tvalid),
    .out_ready     (m_axis_tready)
  );

  // The result word is held in the datapath output register until taken.
  assign m_axis_tdata = {{(TDATA_OUT_W - VALUE_W){1'b0}}, value};

endmodule

// ===== tb/tb_softmax_with_gradient.sv =====
`timescale 1ns / 1ps

module tb_softmax_with_gradient;
  import sms_pkg::*;

  // One word of the input stream: a Q8.8 logit, its one-hot flag and the
  // end-of-vector mark.
  typedef struct {
    logic [LOGIT_W-1:0] logit;
    logic               hot;
    logic               last;
  } logit_word_t;

  // One expected output word: a Q1.16 probability or gradient and its last mark.
  typedef struct {
    logic [VALUE_W-1:0] value;
    logic               last;
  } prob_word_t;

  localparam int MAXN = MAX_ELEMENTS_DEF;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [APB_ADDR_W-1:0]  paddr = '0;
  logic [APB_DATA_W-1:0]  pwdata = '0;
  logic [APB_DATA_W-1:0]  prdata;
  logic                   pready;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [TDATA_IN_W-1:0]  s_axis_tdata = '0;   // [15:0] logit
  logic                   s_axis_tuser = 1'b0; // [0] target_hot
  logic                   s_axis_tlast = 1'b0; // last_element
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [TDATA_OUT_W-1:0] m_axis_tdata;        // [17:0] value, upper bits zero
  logic                   m_axis_tlast;        // last_result

  softmax_with_gradient u_top (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
  );

  always #10 clk = ~clk;

  // Words waiting to be sent, and probabilities the block still owes us.
  logit_word_t logit_words[$];
  prob_word_t  owed_probs[$];

  // Shadow copy of the block: the stored vector, its running maximum and the
  // gradient_mode register.
  logic signed [LOGIT_W-1:0] shadow_logit[MAXN];
  logic                      shadow_hot[MAXN];
  int                        shadow_count = 0;
  logic signed [LOGIT_W-1:0] shadow_peak = '0;
  logic                      shadow_grad = 1'b0;

  int  err_cnt = 0;
  int  vec_cnt = 0;
  int  word_cnt = 0;
  int  result_cnt = 0;
  bit  calm = 1'b0;        // no idling on either side once set
  bit  in_fire = 1'b0;     // input word accepted at the last rising edge
  int  src_gap = 0;
  int  sink_gap = 0;

  // 2^-frac table in Q1.16, indexed by four fraction bits of the exponent.
  function automatic logic [31:0] frac_pow2(input int k);
    logic [31:0] t[16] = '{65536, 62757, 60097, 57549, 55109, 52773, 50535, 48393,
                           46341, 44376, 42495, 40693, 38968, 37316, 35734, 34219};
    return t[k];
  endfunction

  // Approximates e^(x - peak) in Q1.16 as a table value shifted right by the
  // integer part of (peak - x) * log2(e).
  function automatic logic [31:0] exp_q16(input logic signed [LOGIT_W-1:0] x,
                                          input logic signed [LOGIT_W-1:0] peak);
    logic [63:0] d;
    logic [63:0] y;
    logic [63:0] n;
    d = 64'(32'(int'(peak) - int'(x)));
    y = d * 64'd94548;
    n = y >> 24;
    if (n >= 17) return 32'd0;
    return frac_pow2(int'((y >> 20) & 64'd15)) >> n;
  endfunction

  // Takes in one accepted word; on the last one of a vector it queues the
  // softmax (or gradient) of every stored element.
  task automatic softmax_predict(input logic [LOGIT_W-1:0] raw, input logic hot,
                                 input logic last);
    logic [31:0] terms[MAXN];
    logic [63:0] total;
    logic [63:0] p;
    logic [VALUE_W-1:0] v;
    prob_word_t w;
    // Elements beyond the store's capacity are dropped, but their last mark counts.
    if (shadow_count < MAXN) begin
      shadow_logit[shadow_count] = raw;
      shadow_hot[shadow_count] = hot;
      if (shadow_count == 0 || $signed(raw) > shadow_peak) shadow_peak = raw;
      shadow_count++;
    end
    if (!last) return;
    total = 0;
    for (int i = 0; i < shadow_count; i++) begin
      terms[i] = exp_q16(shadow_logit[i], shadow_peak);
      total += terms[i];
    end
    // The peak element contributes 1.0, so total is never zero.
    for (int i = 0; i < shadow_count; i++) begin
      p = ((64'(terms[i]) << 16) + (total >> 1)) / total;
      v = VALUE_W'(p);
      if (shadow_grad && shadow_hot[i]) v = v - VALUE_W'(65536);
      w.value = v;
      w.last = (i + 1 == shadow_count);
      owed_probs.push_back(w);
    end
    vec_cnt++;
    shadow_count = 0;
    shadow_peak = '0;
  endtask

  // Input side: sees each accepted word and feeds it to the predictor.
  always @(posedge clk) begin
    in_fire <= s_axis_tvalid && s_axis_tready;
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      word_cnt++;
      softmax_predict(s_axis_tdata, s_axis_tuser, s_axis_tlast);
    end
  end

  // Driver: a word stays on the bus until it is taken; between words it may
  // insert a random idle burst.
  always @(negedge clk) begin
    logit_word_t w;
    if (!rst && (!s_axis_tvalid || in_fire)) begin
      if (src_gap > 0) begin
        src_gap <= src_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        src_gap <= $urandom_range(0, 3);
        s_axis_tvalid <= 1'b0;
      end else if (logit_words.size() > 0) begin
        w = logit_words.pop_front();
        s_axis_tdata <= w.logit;
        s_axis_tuser <= w.hot;
        s_axis_tlast <= w.last;
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Output side: ready drops in random bursts, and every accepted word is
  // compared against the oldest owed probability.
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (sink_gap > 0) begin
      sink_gap <= sink_gap - 1;
      m_axis_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      sink_gap <= $urandom_range(0, 3);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    prob_word_t w;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      result_cnt++;
      if (owed_probs.size() == 0) begin
        if (err_cnt < 10)
          $display("ERROR: unexpected output word tdata=%h tlast=%b",
                   m_axis_tdata, m_axis_tlast);
        err_cnt++;
      end else begin
        w = owed_probs.pop_front();
        if (m_axis_tdata !== {{(TDATA_OUT_W-VALUE_W){1'b0}}, w.value} ||
            m_axis_tlast !== w.last) begin
          if (err_cnt < 10)
            $display("ERROR: output word expected value=%h last=%b, got tdata=%h tlast=%b",
                     w.value, w.last, m_axis_tdata, m_axis_tlast);
          err_cnt++;
        end
      end
    end
  end

  // Register write: setup phase, then access phase.
  task automatic reg_write(input logic [APB_ADDR_W-1:0] addr,
                           input logic [APB_DATA_W-1:0] data);
    @(negedge clk);
    psel = 1'b1; pwrite = 1'b1; paddr = addr; pwdata = data; penable = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    // Only gradient_mode exists; the shadow follows writes to address 0 only.
    if (addr == 0) shadow_grad = data[0];
  endtask

  task automatic reg_check();
    @(negedge clk);
    psel = 1'b1; pwrite = 1'b0; paddr = '0; penable = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    if (prdata[0] !== shadow_grad) begin
      if (err_cnt < 10)
        $display("ERROR: gradient_mode read expected %b, got %h", shadow_grad, prdata);
      err_cnt++;
    end
    @(negedge clk);
    psel = 1'b0; penable = 1'b0;
  endtask

  task automatic push_word(input logic [LOGIT_W-1:0] x, input logic hot, input logic last);
    logit_word_t w;
    w.logit = x; w.hot = hot; w.last = last;
    logit_words.push_back(w);
  endtask

  // Queues one vector of random logits. A narrow spread keeps most terms
  // above the underflow point; a wide one exercises underflow to zero.
  task automatic push_vector(input int len);
    int base;
    int spread;
    int hot_at;
    logic [LOGIT_W-1:0] x;
    base = $urandom_range(0, 65535);
    spread = ($urandom_range(0, 2) == 0) ? 65535 : $urandom_range(1, 2047);
    hot_at = $urandom_range(0, len - 1);
    for (int i = 0; i < len; i++) begin
      if (spread == 65535) x = LOGIT_W'($urandom_range(0, 65535));
      else x = LOGIT_W'(base + $urandom_range(0, spread));
      // Usually one-hot, sometimes random flags so every pattern shows up.
      push_word(x, ($urandom_range(0, 9) == 0) ? 1'($urandom_range(0, 1)) : (i == hot_at),
                i == len - 1);
    end
  endtask

  // Waits for the block to drain: no word left to send, none owed, then a margin.
  task automatic wait_drained();
    while (logit_words.size() > 0 || s_axis_tvalid || owed_probs.size() > 0)
      @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic random_phase(input int words);
    int sent;
    int len;
    sent = 0;
    while (sent < words) begin
      // Mostly short vectors; now and then a long one, near, at or beyond capacity.
      case ($urandom_range(0, 19))
        0:       len = $urandom_range(60, 70);
        1, 2:    len = $urandom_range(10, 24);
        default: len = $urandom_range(1, 6);
      endcase
      push_vector(len);
      sent += (len > MAXN) ? MAXN : len;
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part, probabilities first: a lone element is exactly 1.0, the
    // field extremes force underflow to zero, and equal logits split evenly.
    reg_check();
    reg_write(0, 0);
    push_word(16'h7FFF, 1'b1, 1'b1);
    push_word(16'h8000, 1'b0, 1'b0);
    push_word(16'h7FFF, 1'b1, 1'b1);
    push_word(16'h0000, 1'b0, 1'b0);
    push_word(16'h0000, 1'b1, 1'b0);
    push_word(16'h0000, 1'b0, 1'b1);
    push_word(16'hFFFF, 1'b0, 1'b0);
    push_word(16'h0100, 1'b1, 1'b0);
    push_word(16'h8000, 1'b0, 1'b1);
    wait_drained();

    // Gradient mode: hot elements come out as p minus 1.0, down to -1.0.
    reg_write(0, 1);
    reg_write(4, 0);   // no register here; must not disturb gradient_mode
    reg_check();
    push_word(16'h8000, 1'b1, 1'b0);
    push_word(16'h7FFF, 1'b0, 1'b1);
    push_word(16'h1234, 1'b1, 1'b1);
    push_word(16'h0080, 1'b0, 1'b0);
    push_word(16'h0000, 1'b1, 1'b0);
    push_word(16'hFF80, 1'b1, 1'b1);
    wait_drained();

    // Random part alternating both register settings; the last stretch runs
    // without idling.
    reg_write(0, 0);
    random_phase(100);
    wait_drained();
    reg_write(0, 1);
    random_phase(100);
    wait_drained();
    reg_write(0, 0);
    random_phase(80);
    wait_drained();
    reg_write(0, 1);
    reg_check();
    calm = 1'b1;
    random_phase(70);
    wait_drained();

    $display("Sent %0d words in %0d vectors and checked %0d output words.",
             word_cnt, vec_cnt, result_cnt);
    $display("Both register settings, underflow and overfull vectors were covered.");
    if (err_cnt == 0) begin
      $display("tb_softmax_with_gradient OK");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("tb_softmax_with_gradient NOT OK");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Timeout with %0d output words still owed", owed_probs.size());
    $display("tb_softmax_with_gradient NOT OK");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/sms_pkg.sv
rtl/sms_ctrl.sv
rtl/sms_dp.sv
rtl/softmax_with_gradient.sv
tb/tb_softmax_with_gradient.sv
